/* rtl/bspline_to_bezier_points_defines.svh */
// ----------------------------------------------------------------------------
// B-spline to Bezier converter assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef BSPLINE_TO_BEZIER_POINTS_DEFINES_SVH
`define BSPLINE_TO_BEZIER_POINTS_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BSP2BEZ_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define BSP2BEZ_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/bsp2bez_pkg.sv */
// ----------------------------------------------------------------------------
// B-spline to Bezier converter package
// Default coordinate width, result kinds and per-result flag bundle.
// ----------------------------------------------------------------------------
package bsp2bez_pkg;

    localparam int COORD_WIDTH_DEF = 32;

    // Which control point of a segment is being produced.
    typedef enum logic [1:0] {
        RES_B0,
        RES_R1,
        RES_R2,
        RES_R3
    } res_kind_t;

    typedef struct packed {
        logic run_last;
        logic curve_done;
        logic too_few;
    } res_meta_t;

endpackage

/* rtl/bsp2bez_if.sv */
// ----------------------------------------------------------------------------
// B-spline to Bezier converter channels
// Valid/ready channels for de Boor points in and Bezier points out.
// ----------------------------------------------------------------------------
interface bsp2bez_point_if
    import bsp2bez_pkg::*;
#(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF
)
();
    logic                          valid;
    logic                          ready;
    logic signed [COORD_WIDTH-1:0] px;
    logic signed [COORD_WIDTH-1:0] py;
    logic signed [COORD_WIDTH-1:0] pz;
    logic                          curve_end;

    modport source (output valid, px, py, pz, curve_end, input ready);
    modport sink   (input valid, px, py, pz, curve_end, output ready);
endinterface

interface bsp2bez_bezier_if
    import bsp2bez_pkg::*;
#(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF
)
();
    logic                          valid;
    logic                          ready;
    logic signed [COORD_WIDTH-1:0] bx;
    logic signed [COORD_WIDTH-1:0] by;
    logic signed [COORD_WIDTH-1:0] bz;
    logic                          run_last;
    logic                          curve_done;
    logic                          too_few;

    modport source (output valid, bx, by, bz, run_last, curve_done, too_few, input ready);
    modport sink   (input valid, bx, by, bz, run_last, curve_done, too_few, output ready);
endinterface

/* rtl/bspline_to_bezier_points.sv */
// ----------------------------------------------------------------------------
// B-spline to Bezier converter top level
// Results pass from the sequencer through s1, s2, s3 and the output register.
// One result per cycle while bezier is ready; a point gives three results (four
// for a first full segment, one at a short-curve end, none for points 1 to 3).
// Reset: asynchronous, active low; clears the window count and all valid bits.
// ----------------------------------------------------------------------------
`include "bspline_to_bezier_points_defines.svh"

module bspline_to_bezier_points
    import bsp2bez_pkg::*;
#(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF
)
(
    input  logic             clk,
    input  logic             rst_n,
    bsp2bez_point_if.sink    point,
    bsp2bez_bezier_if.source bezier
);

    // Every result is a rounded weighted sum divided by three or six. The sum
    // of up to six coordinates needs three extra bits; its magnitude plus the
    // rounding half always fits in two extra bits.
    localparam int SUM_W  = COORD_WIDTH + 3;
    localparam int MAG_W  = COORD_WIDTH + 2;
    // Division by three is a multiply by ceil(2^K/3) and a shift by K. With
    // K two bits above the dividend width the quotient is exact.
    localparam int RCP_K  = MAG_W + 2;
    localparam int LO_W   = MAG_W / 2;
    localparam int HI_W   = MAG_W - LO_W;
    localparam int PLO_W  = LO_W + RCP_K + 1;
    localparam int PHI_W  = HI_W + RCP_K + 1;
    localparam int FULL_W = MAG_W + RCP_K + 1;

    localparam logic [RCP_K:0] ONE_K  = {1'b1, {RCP_K{1'b0}}};
    localparam logic [RCP_K:0] RECIP  = (ONE_K + (RCP_K + 1)'(2)) / (RCP_K + 1)'(3);
    localparam logic [MAG_W-1:0] SIX_HALF   = MAG_W'(3);
    localparam logic [MAG_W-1:0] THREE_HALF = MAG_W'(1);

    // ------------------------------------------------------------------------
    // Pipeline handshake. Each stage loads when it is empty or when the stage
    // after it is moving, so bubbles collapse and a waiting output result does
    // not block the stages in front of it.
    // ------------------------------------------------------------------------
    logic out_valid_reg;
    logic s3_valid_reg;
    logic s2_valid_reg;
    logic s1_valid_reg;
    logic seq_valid_reg;

    logic out_en;
    logic s3_en;
    logic s2_en;
    logic s1_en;
    logic issue;
    logic issue_last;
    logic in_accept;
    logic has_result;

    // Curve window state.
    logic signed [COORD_WIDTH-1:0] pin [3];
    logic signed [COORD_WIDTH-1:0] win_reg [3][3];
    logic [1:0]                    points_seen_reg;
    logic                          b0_sent_reg;

    // Sequencer: holds one accepted point and the window it saw, and issues
    // its results into the arithmetic pipeline one per cycle while s1 can load.
    logic [1:0]                    seq_idx_reg;
    logic                          seq_b0_reg;
    logic                          seq_few_reg;
    logic                          seq_last_reg;
    logic signed [COORD_WIDTH-1:0] seq_win_reg [3][3];
    logic signed [COORD_WIDTH-1:0] seq_x_reg [3];
    logic [1:0]                    last_idx;
    res_kind_t                     kind;
    logic                          kind_six;
    res_meta_t                     issue_meta;

    // Arithmetic pipeline registers.
    logic                    s1_six_reg;
    res_meta_t               s1_meta_reg;
    logic signed [SUM_W-1:0] s1_sum_reg [3];

    res_meta_t               s2_meta_reg;
    logic [MAG_W-1:0]        s2_n_reg [3];
    logic                    s2_neg_reg [3];

    res_meta_t               s3_meta_reg;
    logic [PLO_W-1:0]        s3_lo_reg [3];
    logic [PHI_W-1:0]        s3_hi_reg [3];
    logic                    s3_neg_reg [3];

    res_meta_t                     out_meta_reg;
    logic signed [COORD_WIDTH-1:0] out_coord_reg [3];

    assign out_en = !out_valid_reg || bezier.ready;
    assign s3_en  = !s3_valid_reg || out_en;
    assign s2_en  = !s2_valid_reg || s3_en;
    assign s1_en  = !s1_valid_reg || s2_en;
    assign issue  = seq_valid_reg && s1_en;

    // A short curve gives one result; a full segment gives three, plus the
    // leading B0 for the first segment of a curve.
    assign last_idx   = seq_few_reg ? 2'd0 : (seq_b0_reg ? 2'd3 : 2'd2);
    assign issue_last = (seq_idx_reg == last_idx);

    // A new request is taken as soon as the sequencer is empty or hands off
    // its final result in this cycle.
    assign point.ready = !seq_valid_reg || (issue && issue_last);
    assign in_accept   = point.valid && point.ready;

    // The first three points of a curve only fill the window, unless the
    // curve ends there.
    assign has_result = (points_seen_reg == 2'd3) || point.curve_end;

    assign pin[0] = point.px;
    assign pin[1] = point.py;
    assign pin[2] = point.pz;

    // Without a B0 to send, the first issued result is the first third point.
    assign kind     = res_kind_t'(seq_idx_reg + {1'b0, !seq_b0_reg});
    assign kind_six = (kind == RES_B0) || (kind == RES_R3);

    assign issue_meta.run_last   = issue_last;
    assign issue_meta.curve_done = issue_last && seq_last_reg;
    assign issue_meta.too_few    = seq_few_reg;

    // ------------------------------------------------------------------------
    // Control state.
    // ------------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            points_seen_reg <= 2'd0;
            b0_sent_reg     <= 1'b0;
            seq_valid_reg   <= 1'b0;
            seq_idx_reg     <= 2'd0;
            s1_valid_reg    <= 1'b0;
            s2_valid_reg    <= 1'b0;
            s3_valid_reg    <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (in_accept)
            begin
                if (point.curve_end)
                begin
                    points_seen_reg <= 2'd0;
                    b0_sent_reg     <= 1'b0;
                end
                else if (points_seen_reg == 2'd3)
                begin
                    b0_sent_reg <= 1'b1;
                end
                else
                begin
                    points_seen_reg <= points_seen_reg + 2'd1;
                end
                seq_valid_reg <= has_result;
                seq_idx_reg   <= 2'd0;
            end
            else if (issue)
            begin
                if (issue_last)
                begin
                    seq_valid_reg <= 1'b0;
                end
                seq_idx_reg <= seq_idx_reg + 2'd1;
            end

            if (s1_en)
            begin
                s1_valid_reg <= issue;
            end
            if (s2_en)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
            if (s3_en)
            begin
                s3_valid_reg <= s2_valid_reg;
            end
            if (out_en)
            begin
                out_valid_reg <= s3_valid_reg;
            end
        end
    end

    // Flags that travel with each result.
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            seq_b0_reg   <= !b0_sent_reg;
            seq_few_reg  <= (points_seen_reg != 2'd3);
            seq_last_reg <= point.curve_end;
        end
        if (s1_en)
        begin
            s1_six_reg  <= kind_six;
            s1_meta_reg <= issue_meta;
        end
        if (s2_en)
        begin
            s2_meta_reg <= s1_meta_reg;
        end
        if (s3_en)
        begin
            s3_meta_reg <= s2_meta_reg;
        end
        if (out_en)
        begin
            out_meta_reg <= s3_meta_reg;
        end
    end

    // ------------------------------------------------------------------------
    // One lane per coordinate axis.
    // ------------------------------------------------------------------------
    for (genvar lane = 0; lane < 3; lane++)
    begin : g_lane
        logic signed [COORD_WIDTH-1:0] op_a;
        logic signed [COORD_WIDTH-1:0] op_b;
        logic signed [COORD_WIDTH-1:0] op_c;
        logic signed [SUM_W-1:0]       ext_a;
        logic signed [SUM_W-1:0]       ext_b;
        logic signed [SUM_W-1:0]       ext_c;
        logic signed [SUM_W-1:0]       sum_next;
        logic [SUM_W-1:0]              abs_sum;
        logic [MAG_W-1:0]              mag;
        logic [MAG_W-1:0]              n_next;
        logic [FULL_W-1:0]             full;
        logic [MAG_W-1:0]              quot;
        logic [MAG_W-1:0]              signed_q;

        // The window shifts on every accepted point; its contents are only
        // read once three points of the current curve are in.
        always_ff @(posedge clk)
        begin
            if (in_accept)
            begin
                win_reg[lane][0]     <= win_reg[lane][1];
                win_reg[lane][1]     <= win_reg[lane][2];
                win_reg[lane][2]     <= pin[lane];
                seq_win_reg[lane][0] <= win_reg[lane][0];
                seq_win_reg[lane][1] <= win_reg[lane][1];
                seq_win_reg[lane][2] <= win_reg[lane][2];
                seq_x_reg[lane]      <= pin[lane];
            end
        end

        // Operand choice. Sixths take a + 4b + c, thirds take 2a + b.
        always_comb
        begin
            op_a = seq_win_reg[lane][1];
            op_b = seq_win_reg[lane][2];
            op_c = '0;
            case (kind)
                RES_B0:
                begin
                    op_a = seq_win_reg[lane][0];
                    op_b = seq_win_reg[lane][1];
                    op_c = seq_win_reg[lane][2];
                end
                RES_R1:
                begin
                    op_a = seq_win_reg[lane][1];
                    op_b = seq_win_reg[lane][2];
                end
                RES_R2:
                begin
                    op_a = seq_win_reg[lane][2];
                    op_b = seq_win_reg[lane][1];
                end
                RES_R3:
                begin
                    op_c = seq_x_reg[lane];
                end
                default:
                begin
                    op_c = '0;
                end
            endcase
        end

        assign ext_a = SUM_W'(op_a);
        assign ext_b = SUM_W'(op_b);
        assign ext_c = SUM_W'(op_c);

        always_comb
        begin
            if (seq_few_reg)
            begin
                sum_next = '0;
            end
            else if (kind_six)
            begin
                sum_next = ext_a + (ext_b <<< 2) + ext_c;
            end
            else
            begin
                sum_next = (ext_a <<< 1) + ext_b;
            end
        end

        // Round half away from zero on the magnitude. A sixth is a third of
        // the halved value, so one divider by three serves both.
        assign abs_sum = s1_sum_reg[lane][SUM_W-1] ? -s1_sum_reg[lane] : s1_sum_reg[lane];
        assign mag     = abs_sum[MAG_W-1:0] + (s1_six_reg ? SIX_HALF : THREE_HALF);
        assign n_next  = s1_six_reg ? (mag >> 1) : mag;

        // Recombine the two partial products and take the quotient bits.
        assign full     = (FULL_W'(s3_hi_reg[lane]) << LO_W) + FULL_W'(s3_lo_reg[lane]);
        assign quot     = full[RCP_K +: MAG_W];
        assign signed_q = s3_neg_reg[lane] ? -quot : quot;

        always_ff @(posedge clk)
        begin
            if (s1_en)
            begin
                s1_sum_reg[lane] <= sum_next;
            end
            if (s2_en)
            begin
                s2_n_reg[lane]   <= n_next;
                s2_neg_reg[lane] <= s1_sum_reg[lane][SUM_W-1];
            end
            if (s3_en)
            begin
                s3_lo_reg[lane]  <= PLO_W'(s2_n_reg[lane][LO_W-1:0]) * PLO_W'(RECIP);
                s3_hi_reg[lane]  <= PHI_W'(s2_n_reg[lane][MAG_W-1:LO_W]) * PHI_W'(RECIP);
                s3_neg_reg[lane] <= s2_neg_reg[lane];
            end
            if (out_en)
            begin
                out_coord_reg[lane] <= signed_q[COORD_WIDTH-1:0];
            end
        end
    end

    // ------------------------------------------------------------------------
    // Output register drives the result channel directly.
    // ------------------------------------------------------------------------
    assign bezier.valid      = out_valid_reg;
    assign bezier.bx         = out_coord_reg[0];
    assign bezier.by         = out_coord_reg[1];
    assign bezier.bz         = out_coord_reg[2];
    assign bezier.run_last   = out_meta_reg.run_last;
    assign bezier.curve_done = out_meta_reg.curve_done;
    assign bezier.too_few    = out_meta_reg.too_few;

    // ------------------------------------------------------------------------
    // Assertions.
    // ------------------------------------------------------------------------
    `BSP2BEZ_ASSERT_NOW(a_short_curve_zero, bezier.valid && bezier.too_few,
        bezier.bx == '0 && bezier.by == '0 && bezier.bz == '0
            && bezier.run_last && bezier.curve_done,
        "short-curve result is not a lone zero point")
    `BSP2BEZ_ASSERT_NEXT(a_end_clears_window, in_accept && point.curve_end,
        points_seen_reg == 2'd0 && !b0_sent_reg,
        "curve end did not clear the window state")
    `BSP2BEZ_ASSERT_NOW(a_seq_index_bound, seq_valid_reg, seq_idx_reg <= last_idx,
        "sequencer index ran past the last result")

endmodule
